// ===== rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes for the I2C master bit/byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	localparam int DELAY_WIDTH_DEF = 12;

	// register widths and reset values
	localparam int BIT_DLY_W  = 8;
	localparam int WAKE_DLY_W = 12;
	localparam int CFG_W      = 12;
	localparam int CFG_IDX_W  = 2;

	localparam logic [BIT_DLY_W-1:0]  BIT_DLY_RST   = 8'd4;
	localparam logic [WAKE_DLY_W-1:0] WAKE_LO_RST   = 12'd70;
	localparam logic [WAKE_DLY_W-1:0] WAKE_WAIT_RST = 12'd2600;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BIT_DLY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAKE_LO   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAKE_WAIT = 2'd2;

	// command codes
	localparam logic [2:0] CMD_TICK  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;
	localparam logic [2:0] CMD_WAKE  = 3'd5;

	// sequencer phases
	localparam logic [3:0] PH_IDLE      = 4'd0;
	localparam logic [3:0] PH_START_W   = 4'd1;
	localparam logic [3:0] PH_STOP_W1   = 4'd2;
	localparam logic [3:0] PH_STOP_SCL  = 4'd3;
	localparam logic [3:0] PH_STOP_W2   = 4'd4;
	localparam logic [3:0] PH_STOP_W3   = 4'd5;
	localparam logic [3:0] PH_WAKE_LO   = 4'd6;
	localparam logic [3:0] PH_WAKE_WAIT = 4'd7;
	localparam logic [3:0] PH_SB_W1     = 4'd8;
	localparam logic [3:0] PH_SB_W2     = 4'd9;
	localparam logic [3:0] PH_SB_SCL    = 4'd10;
	localparam logic [3:0] PH_RB_W1     = 4'd11;
	localparam logic [3:0] PH_RB_SCL    = 4'd12;
	localparam logic [3:0] PH_RB_W2     = 4'd13;

	localparam int IN_BITS  = 14;
	localparam int OUT_BITS = 14;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;

	typedef struct packed {
		logic       sda_in;
		logic       scl_in;
		logic       nack_flag;
		logic [7:0] wr_byte;
		logic [2:0] cmd;
	} item_t;

	typedef struct packed {
		logic       rejected;
		logic       busy_res;
		logic [7:0] rd_byte;
		logic       ack_bit;
		logic       done_res;
		logic       sda_low;
		logic       scl_low;
	} res_t;

	typedef struct packed {
		logic [BIT_DLY_W-1:0]  bit_dly;
		logic [WAKE_DLY_W-1:0] wake_lo;
		logic [WAKE_DLY_W-1:0] wake_wait;
	} cfg_t;

endpackage

// ===== rtl/i2cm_cfg.sv =====
// ----------------------------------------------------------------------------
// i2cm_cfg
// Configuration register file: bit delay and wake timing.
// ----------------------------------------------------------------------------
module i2cm_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [i2cm_pkg::CFG_W-1:0]     cfg_wdata,
	output i2cm_pkg::cfg_t                cfg
);
	import i2cm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_dly   <= BIT_DLY_RST;
			cfg_q.wake_lo   <= WAKE_LO_RST;
			cfg_q.wake_wait <= WAKE_WAIT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_BIT_DLY:   cfg_q.bit_dly   <= cfg_wdata[BIT_DLY_W-1:0];
				REG_WAKE_LO:   cfg_q.wake_lo   <= cfg_wdata[WAKE_DLY_W-1:0];
				REG_WAKE_WAIT: cfg_q.wake_wait <= cfg_wdata[WAKE_DLY_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/i2cm_engine.sv =====
// ----------------------------------------------------------------------------
// i2cm_engine
// Sequencer state and next-state logic; updates once per processed word.
// ----------------------------------------------------------------------------
module i2cm_engine #(
	parameter int DELAY_WIDTH = i2cm_pkg::DELAY_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  i2cm_pkg::item_t item,
	input  i2cm_pkg::cfg_t  cfg,
	output i2cm_pkg::res_t  res
);
	import i2cm_pkg::*;

	localparam int LW = (DELAY_WIDTH > WAKE_DLY_W) ? DELAY_WIDTH : WAKE_DLY_W;
	localparam logic [LW-1:0] DLY_MAX = LW'({DELAY_WIDTH{1'b1}});

	// saturating delay load
	function automatic logic [DELAY_WIDTH-1:0] load_dly(input logic [WAKE_DLY_W-1:0] v);
		logic [LW-1:0] ext;
		ext = LW'(v);
		if (ext > DLY_MAX)
			ext = DLY_MAX;
		return ext[DELAY_WIDTH-1:0];
	endfunction

	logic [3:0]             phase_q, n_phase;
	logic [DELAY_WIDTH-1:0] dly_q, n_dly, dly_dec;
	logic [3:0]             bi_q, n_bi;
	logic [7:0]             sr_q, n_sr;
	logic [7:0]             rd_q, n_rd;
	logic [2:0]             act_q, n_act;
	logic                   ack_q, n_ack;
	logic                   scl_q, n_scl;
	logic                   sda_q, n_sda;
	logic                   nack_q, n_nack;

	logic dly_exp, is_cmd, do_end, do_begin, end_b, send, send_b, done, rej;

	assign dly_exp = (dly_q <= DELAY_WIDTH'(1));
	assign dly_dec = dly_exp ? '0 : dly_q - DELAY_WIDTH'(1);
	assign is_cmd  = (item.cmd >= CMD_START) && (item.cmd <= CMD_WAKE);

	always_comb begin
		n_phase  = phase_q;
		n_dly    = dly_q;
		n_bi     = bi_q;
		n_sr     = sr_q;
		n_rd     = rd_q;
		n_act    = act_q;
		n_ack    = ack_q;
		n_scl    = scl_q;
		n_sda    = sda_q;
		n_nack   = nack_q;
		do_end   = 1'b0;
		do_begin = 1'b0;
		end_b    = 1'b0;
		send     = 1'b0;
		send_b   = 1'b0;
		done     = 1'b0;
		rej      = 1'b0;

		if (is_cmd && phase_q != PH_IDLE) begin
			rej = 1'b1;
		end else if (is_cmd) begin
			n_act = item.cmd;
			case (item.cmd)
				CMD_START: begin
					n_sda   = 1'b1;
					n_dly   = load_dly(WAKE_DLY_W'(cfg.bit_dly));
					n_phase = PH_START_W;
				end
				CMD_STOP: begin
					n_sda   = 1'b1;
					n_dly   = load_dly(WAKE_DLY_W'(cfg.bit_dly));
					n_phase = PH_STOP_W1;
				end
				CMD_WRITE, CMD_READ: begin
					n_sr     = (item.cmd == CMD_WRITE) ? item.wr_byte : 8'd0;
					n_nack   = item.nack_flag;
					n_bi     = 4'd0;
					do_begin = 1'b1;
				end
				default: begin
					n_sda   = 1'b1;
					n_dly   = load_dly(cfg.wake_lo);
					n_phase = PH_WAKE_LO;
				end
			endcase
		end else begin
			case (phase_q)
				PH_IDLE: ;
				PH_START_W: begin
					n_dly = dly_dec;
					if (dly_exp) begin
						n_scl   = 1'b1;
						n_phase = PH_IDLE;
						done    = 1'b1;
					end
				end
				PH_STOP_W1: begin
					n_dly = dly_dec;
					if (dly_exp) begin
						n_scl   = 1'b0;
						n_phase = PH_STOP_SCL;
					end
				end
				PH_STOP_SCL: begin
					if (item.scl_in) begin
						n_dly   = load_dly(WAKE_DLY_W'(cfg.bit_dly));
						n_phase = PH_STOP_W2;
					end
				end
				PH_STOP_W2: begin
					n_dly = dly_dec;
					if (dly_exp) begin
						n_sda   = 1'b0;
						n_dly   = load_dly(WAKE_DLY_W'(cfg.bit_dly));
						n_phase = PH_STOP_W3;
					end
				end
				PH_STOP_W3, PH_WAKE_WAIT: begin
					n_dly = dly_dec;
					if (dly_exp) begin
						n_phase = PH_IDLE;
						done    = 1'b1;
					end
				end
				PH_WAKE_LO: begin
					n_dly = dly_dec;
					if (dly_exp) begin
						n_sda   = 1'b0;
						n_dly   = load_dly(cfg.wake_wait);
						n_phase = PH_WAKE_WAIT;
					end
				end
				PH_SB_W1: begin
					n_dly = dly_dec;
					if (dly_exp) begin
						n_scl   = 1'b0;
						n_dly   = load_dly(WAKE_DLY_W'(cfg.bit_dly));
						n_phase = PH_SB_W2;
					end
				end
				PH_SB_W2: begin
					n_dly = dly_dec;
					if (dly_exp) begin
						if (item.scl_in)
							do_end = 1'b1;
						else
							n_phase = PH_SB_SCL;
					end
				end
				PH_SB_SCL: begin
					if (item.scl_in)
						do_end = 1'b1;
				end
				PH_RB_W1: begin
					n_dly = dly_dec;
					if (dly_exp) begin
						n_scl   = 1'b0;
						n_phase = PH_RB_SCL;
					end
				end
				PH_RB_SCL: begin
					if (item.scl_in) begin
						n_dly   = load_dly(WAKE_DLY_W'(cfg.bit_dly));
						n_phase = PH_RB_W2;
					end
				end
				PH_RB_W2: begin
					n_dly = dly_dec;
					if (dly_exp) begin
						do_end = 1'b1;
						end_b  = item.sda_in;
					end
				end
				default: n_phase = PH_IDLE;
			endcase
		end

		// close out a bit: pull SCL low, shift, count
		if (do_end) begin
			n_scl = 1'b1;
			if (act_q == CMD_WRITE) begin
				if (bi_q < 4'd8)
					n_sr = {sr_q[6:0], 1'b0};
				else
					n_ack = end_b;
			end else begin
				if (bi_q < 4'd8)
					n_sr = {sr_q[6:0], end_b};
				else
					n_rd = sr_q;
			end
			n_bi = bi_q + 4'd1;
			if (n_bi > 4'd8) begin
				n_phase = PH_IDLE;
				done    = 1'b1;
			end else begin
				do_begin = 1'b1;
			end
		end

		// open a bit: set SDA, start first delay
		if (do_begin) begin
			if (n_act == CMD_WRITE) begin
				send   = (n_bi < 4'd8);
				send_b = n_sr[7];
			end else begin
				send   = (n_bi >= 4'd8);
				send_b = n_nack;
			end
			n_sda   = send ? !send_b : 1'b0;
			n_phase = send ? PH_SB_W1 : PH_RB_W1;
			n_dly   = load_dly(WAKE_DLY_W'(cfg.bit_dly));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			dly_q   <= '0;
			bi_q    <= '0;
			sr_q    <= '0;
			rd_q    <= '0;
			act_q   <= CMD_TICK;
			ack_q   <= 1'b0;
			scl_q   <= 1'b0;
			sda_q   <= 1'b0;
			nack_q  <= 1'b0;
		end else if (en) begin
			phase_q <= n_phase;
			dly_q   <= n_dly;
			bi_q    <= n_bi;
			sr_q    <= n_sr;
			rd_q    <= n_rd;
			act_q   <= n_act;
			ack_q   <= n_ack;
			scl_q   <= n_scl;
			sda_q   <= n_sda;
			nack_q  <= n_nack;
		end
	end

	always_comb begin
		res.scl_low  = n_scl;
		res.sda_low  = n_sda;
		res.done_res = done;
		res.ack_bit  = n_ack;
		res.rd_byte  = n_rd;
		res.busy_res = (n_phase != PH_IDLE);
		res.rejected = rej;
	end

endmodule

// ===== rtl/i2c_master_bit_byte_engine_top.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_byte_engine_top
// Open-drain I2C master bit/byte engine with stream in/out and config port.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tick or command word (14 bits in 16)
// m_*       out  m_tvalid/m_tready  line drives and status word (14 bits in 16)
// cfg_*     in   cfg_we             register index + write data
//
// One word per cycle sustained while m_tready is high. A word is captured in
// the input register, runs through the sequencer's next-state logic, and its
// result lands in the output register once the output slot is free.
// When the output register holds an untaken word the input register still
// fills, so the input stalls only when both are full.
// Reset (arst_n low) clears the sequencer to idle with both lines released
// and loads the delay registers with 4, 70 and 2600.
// ----------------------------------------------------------------------------
module i2c_master_bit_byte_engine_top #(
	parameter int DELAY_WIDTH = i2cm_pkg::DELAY_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// cmd[2:0], wr_byte[10:3], nack_flag[11], scl_in[12], sda_in[13], zero pad
	input  logic [i2cm_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// scl_low[0], sda_low[1], done_res[2], ack_bit[3], rd_byte[11:4],
	// busy_res[12], rejected[13], zero pad
	output logic [i2cm_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic                              cfg_we,
	input  logic [i2cm_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [i2cm_pkg::CFG_W-1:0]         cfg_wdata
);
	import i2cm_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res;
	res_t  res_q;
	logic  m_valid_q;
	logic  advance;

	// the word in the input register moves when the output slot is free
	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			item_s1 <= item_t'(s_tdata[IN_BITS-1:0]);
	end

	i2cm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// sequencer state steps only when its word is handed on
	i2cm_engine #(
		.DELAY_WIDTH (DELAY_WIDTH)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, res_q};

endmodule

// ===== verif/i2c_master_bit_byte_engine_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_byte_engine_top_tb
// Drives tick and command words into the I2C master engine and checks every
// status word. A scoreboard runs its own copy of the sequencer. It covers the
// reset register values, the minimum and maximum values, the zero delay and
// random settings, with SCL stretching and random stalls on both streams.
// ----------------------------------------------------------------------------
import i2cm_pkg::*;

class i2c_engine_scoreboard;
	logic [BIT_DLY_W-1:0]  bit_dly;
	logic [WAKE_DLY_W-1:0] wake_lo;
	logic [WAKE_DLY_W-1:0] wake_wait;

	logic [3:0]  phase;
	int unsigned dly_cnt;
	logic [3:0]  bit_idx;
	logic [7:0]  shreg;
	logic [7:0]  rd_hold;
	logic        ack_hold;
	logic        scl_drv;
	logic        sda_drv;
	logic        nack_keep;
	logic        done_now;
	logic [2:0]  act_cmd;

	res_t pending_status[$];
	int   errors;

	function new();
		bit_dly   = BIT_DLY_RST;
		wake_lo   = WAKE_LO_RST;
		wake_wait = WAKE_WAIT_RST;
		phase     = PH_IDLE;
		dly_cnt   = 0;
		bit_idx   = '0;
		shreg     = '0;
		rd_hold   = '0;
		ack_hold  = 1'b0;
		scl_drv   = 1'b0;
		sda_drv   = 1'b0;
		nack_keep = 1'b0;
		done_now  = 1'b0;
		act_cmd   = CMD_TICK;
		errors    = 0;
	endfunction

	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		case (idx)
			REG_BIT_DLY:   bit_dly = val[BIT_DLY_W-1:0];
			REG_WAKE_LO:   wake_lo = val[WAKE_DLY_W-1:0];
			REG_WAKE_WAIT: wake_wait = val[WAKE_DLY_W-1:0];
			default: ;
		endcase
	endfunction

	function bit busy();
		return phase != PH_IDLE;
	endfunction

	function int pending();
		return pending_status.size();
	endfunction

	// counter saturates at the top of its width
	function void load_count(int unsigned v);
		int unsigned top;
		top = (1 << DELAY_WIDTH_DEF) - 1;
		dly_cnt = (v > top) ? top : v;
	endfunction

	// zero or one left both expire on this tick
	function bit count_out();
		if (dly_cnt > 1) begin
			dly_cnt--;
			return 1'b0;
		end
		dly_cnt = 0;
		return 1'b1;
	endfunction

	function void finish_cmd();
		phase    = PH_IDLE;
		done_now = 1'b1;
	endfunction

	// write: data bits driven, then ACK sampled; read: 8 sampled, then ACK sent
	function void start_bit();
		bit send_it;
		bit b;
		if (act_cmd == CMD_WRITE) begin
			send_it = (bit_idx < 4'd8);
			b       = shreg[7];
		end else begin
			send_it = (bit_idx >= 4'd8);
			b       = nack_keep;
		end
		if (send_it) begin
			sda_drv = !b;
			phase   = PH_SB_W1;
		end else begin
			sda_drv = 1'b0;
			phase   = PH_RB_W1;
		end
		load_count(32'(bit_dly));
	endfunction

	function void close_bit(bit b);
		scl_drv = 1'b1;
		if (act_cmd == CMD_WRITE) begin
			if (bit_idx < 4'd8)
				shreg = shreg << 1;
			else
				ack_hold = b;
		end else begin
			if (bit_idx < 4'd8)
				shreg = {shreg[6:0], b};
			else
				rd_hold = shreg;
		end
		bit_idx = bit_idx + 4'd1;
		if (bit_idx > 4'd8)
			finish_cmd();
		else
			start_bit();
	endfunction

	function void step_tick(bit scl_in, bit sda_in);
		case (phase)
			PH_START_W: begin
				if (count_out()) begin
					scl_drv = 1'b1;
					finish_cmd();
				end
			end
			PH_STOP_W1: begin
				if (count_out()) begin
					scl_drv = 1'b0;
					phase   = PH_STOP_SCL;
				end
			end
			PH_STOP_SCL: begin
				if (scl_in) begin
					load_count(32'(bit_dly));
					phase = PH_STOP_W2;
				end
			end
			PH_STOP_W2: begin
				if (count_out()) begin
					sda_drv = 1'b0;
					load_count(32'(bit_dly));
					phase = PH_STOP_W3;
				end
			end
			PH_STOP_W3: begin
				if (count_out())
					finish_cmd();
			end
			PH_WAKE_LO: begin
				if (count_out()) begin
					sda_drv = 1'b0;
					load_count(32'(wake_wait));
					phase = PH_WAKE_WAIT;
				end
			end
			PH_WAKE_WAIT: begin
				if (count_out())
					finish_cmd();
			end
			PH_SB_W1: begin
				if (count_out()) begin
					scl_drv = 1'b0;
					load_count(32'(bit_dly));
					phase = PH_SB_W2;
				end
			end
			PH_SB_W2: begin
				// SCL seen on the same tick the second delay runs out
				if (count_out()) begin
					if (scl_in)
						close_bit(1'b0);
					else
						phase = PH_SB_SCL;
				end
			end
			PH_SB_SCL: begin
				if (scl_in)
					close_bit(1'b0);
			end
			PH_RB_W1: begin
				if (count_out()) begin
					scl_drv = 1'b0;
					phase   = PH_RB_SCL;
				end
			end
			PH_RB_SCL: begin
				if (scl_in) begin
					load_count(32'(bit_dly));
					phase = PH_RB_W2;
				end
			end
			PH_RB_W2: begin
				if (count_out())
					close_bit(sda_in);
			end
			default: phase = PH_IDLE;
		endcase
	endfunction

	// one accepted input word -> one expected status word
	function void note_word(item_t w);
		res_t r;
		bit   is_cmd;
		bit   rej;
		is_cmd   = (w.cmd >= CMD_START) && (w.cmd <= CMD_WAKE);
		rej      = 1'b0;
		done_now = 1'b0;
		if (is_cmd && busy()) begin
			rej = 1'b1;
		end else if (is_cmd) begin
			act_cmd = w.cmd;
			case (w.cmd)
				CMD_START: begin
					sda_drv = 1'b1;
					load_count(32'(bit_dly));
					phase = PH_START_W;
				end
				CMD_STOP: begin
					sda_drv = 1'b1;
					load_count(32'(bit_dly));
					phase = PH_STOP_W1;
				end
				CMD_WRITE, CMD_READ: begin
					shreg     = (w.cmd == CMD_WRITE) ? w.wr_byte : 8'h00;
					nack_keep = w.nack_flag;
					bit_idx   = '0;
					start_bit();
				end
				default: begin
					sda_drv = 1'b1;
					load_count(32'(wake_lo));
					phase = PH_WAKE_LO;
				end
			endcase
		end else begin
			step_tick(w.scl_in, w.sda_in);
		end
		r.scl_low  = scl_drv;
		r.sda_low  = sda_drv;
		r.done_res = done_now;
		r.ack_bit  = ack_hold;
		r.rd_byte  = rd_hold;
		r.busy_res = busy();
		r.rejected = rej;
		pending_status.push_back(r);
	endfunction

	function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	function void check_word(logic [OUT_TDATA_W-1:0] d);
		res_t got;
		res_t want;
		got = d[OUT_BITS-1:0];
		if (pending_status.size() == 0) begin
			$error("status word %h with nothing expected", d);
			errors++;
			return;
		end
		want = pending_status.pop_front();
		cmp_field("scl_low", 8'(want.scl_low), 8'(got.scl_low));
		cmp_field("sda_low", 8'(want.sda_low), 8'(got.sda_low));
		cmp_field("done_res", 8'(want.done_res), 8'(got.done_res));
		cmp_field("ack_bit", 8'(want.ack_bit), 8'(got.ack_bit));
		cmp_field("rd_byte", want.rd_byte, got.rd_byte);
		cmp_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
		cmp_field("rejected", 8'(want.rejected), 8'(got.rejected));
		cmp_field("pad", 8'd0, 8'(d[OUT_TDATA_W-1:OUT_BITS]));
	endfunction
endclass

module i2c_master_bit_byte_engine_top_tb;
	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	// codes past wake, handled as ticks
	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	// what ticks put on sda_in
	localparam int SDA_LOW  = 0;
	localparam int SDA_HIGH = 1;
	localparam int SDA_RAND = 2;
	// extra drain wait, as margin
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 1_000_000;

	logic                   clk;
	logic                   arst_n;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_idx;
	logic [CFG_W-1:0]       cfg_wdata;

	// set for the tail of the run: no gaps, no stalls
	bit calm;

	i2c_engine_scoreboard sb;

	i2c_master_bit_byte_engine_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop if the engine hangs or the stream stalls for good
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	// Result side: check on each accepted word, stall in short bursts.
	// Values read right after the edge are the ones the edge sampled.
	initial begin
		int stall;
		stall = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_word(m_tdata);
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// One word per call. Valid stays high on return so back-to-back words
	// never drop it; anything that pauses lowers it first.
	task automatic send_word(input item_t w);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W - IN_BITS){1'b0}}, w};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_word(w);
	endtask

	// tick with SCL mostly released-high; low reads model a stretching slave
	function automatic item_t tick_word(int sda_mode);
		item_t w;
		w.cmd       = CMD_TICK;
		w.wr_byte   = 8'($urandom);
		w.nack_flag = 1'($urandom);
		w.scl_in    = ($urandom_range(0, 7) != 0);
		case (sda_mode)
			SDA_LOW:  w.sda_in = 1'b0;
			SDA_HIGH: w.sda_in = 1'b1;
			default:  w.sda_in = 1'($urandom);
		endcase
		return w;
	endfunction

	function automatic item_t cmd_word(logic [2:0] cmd, logic [7:0] wr, logic nack);
		item_t w;
		w           = tick_word(SDA_RAND);
		w.cmd       = cmd;
		w.wr_byte   = wr;
		w.nack_flag = nack;
		return w;
	endfunction

	// Random stream. Idle: mostly well-formed commands. Busy: mostly ticks,
	// with some rejected commands and spare codes mixed in.
	function automatic item_t pick_word();
		item_t w;
		int    r;
		w = tick_word(SDA_RAND);
		r = $urandom_range(0, 99);
		if (!sb.busy()) begin
			if (r < 20)
				w.cmd = CMD_START;
			else if (r < 48)
				w.cmd = CMD_WRITE;
			else if (r < 74)
				w.cmd = CMD_READ;
			else if (r < 90)
				w.cmd = CMD_STOP;
			else if (r < 93)
				w.cmd = CMD_WAKE;
			else if (r < 96)
				w.cmd = CMD_TICK;
			else
				w.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		end else begin
			if (r < 5)
				w.cmd = 3'($urandom_range(CMD_START, CMD_WAKE));
			else if (r < 10)
				w.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		end
		return w;
	endfunction

	// sender holds off until every status word is back
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// tick the current command out, then go quiet
	task automatic finish_phase();
		while (sb.busy()) send_word(tick_word(SDA_RAND));
		settle();
	endtask

	// command, a stretch of SCL held low, then ticks until it completes
	task automatic run_cmd(input logic [2:0] cmd, input logic [7:0] wr, input logic nack,
		input int sda_mode, input int hold_low);
		item_t w;
		send_word(cmd_word(cmd, wr, nack));
		repeat (hold_low) begin
			w        = tick_word(sda_mode);
			w.scl_in = 1'b0;
			send_word(w);
		end
		while (sb.busy()) send_word(tick_word(sda_mode));
	endtask

	// caller leaves cfg_we high between back-to-back writes
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	// only called with the engine idle and nothing in flight
	task automatic program_regs(input logic [CFG_W-1:0] bit_val, input logic [CFG_W-1:0] lo_val,
		input logic [CFG_W-1:0] wait_val, input bit spare);
		write_reg(REG_BIT_DLY, bit_val);
		write_reg(REG_WAKE_LO, lo_val);
		write_reg(REG_WAKE_WAIT, wait_val);
		if (spare)
			write_reg(REG_SPARE, CFG_W'($urandom));
		cfg_we <= 1'b0;
	endtask

	task automatic random_run(input int budget, input bit quiet_tail);
		int k;
		for (k = 0; k < budget; k++) begin
			if (k == budget / 2) begin
				settle();
				if (quiet_tail)
					calm = 1'b1;
			end
			send_word(pick_word());
		end
		finish_phase();
	endtask

	initial begin
		item_t w;
		sb        = new();
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_we    <= 1'b0;
		cfg_idx   <= '0;
		cfg_wdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed, reset register values (4 / 70 / 2600) ---
		// idle ticks with every field but cmd at all-ones, then all at zero
		w     = '1;
		w.cmd = CMD_TICK;
		send_word(w);
		send_word('0);
		// spare codes while idle do nothing
		send_word(cmd_word(CMD_SPARE_LO, 8'h00, 1'b0));
		send_word(cmd_word(CMD_SPARE_HI, 8'hFF, 1'b1));
		// start; a command and a spare code while it runs
		send_word(cmd_word(CMD_START, 8'h00, 1'b0));
		send_word(cmd_word(CMD_WRITE, 8'hFF, 1'b1));
		send_word(cmd_word(CMD_SPARE_HI, 8'h00, 1'b0));
		finish_phase();
		// writes: slave ACKs, slave NACKs, and a long stretch on a data bit
		run_cmd(CMD_WRITE, 8'hFF, 1'b0, SDA_LOW, 0);
		run_cmd(CMD_WRITE, 8'h00, 1'b1, SDA_HIGH, 0);
		run_cmd(CMD_WRITE, 8'hA5, 1'b0, SDA_RAND, 30);
		// reads: all ones then ACK, all zeros then NACK, random with stretch
		run_cmd(CMD_READ, 8'h3C, 1'b0, SDA_HIGH, 0);
		run_cmd(CMD_READ, 8'hFF, 1'b1, SDA_LOW, 0);
		run_cmd(CMD_READ, 8'($urandom), 1'($urandom), SDA_RAND, 20);
		// stop with SCL held low past its first delay
		run_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RAND, 12);
		finish_phase();

		// --- minimum delays, plus a write to the unmapped index ---
		program_regs(12'd1, 12'd1, 12'd1, 1'b1);
		run_cmd(CMD_WAKE, 8'h00, 1'b0, SDA_RAND, 0);
		random_run(150, 1'b0);
		// bit delay gets 0 from a value with only bit 8 set; wake delays zero
		program_regs(12'h100, 12'd0, 12'd0, 1'b0);
		run_cmd(CMD_WAKE, 8'h00, 1'b0, SDA_RAND, 0);
		random_run(150, 1'b0);
		// maximum delays: one start runs out the longest bit delay
		program_regs(12'd255, 12'd4095, 12'd4095, 1'b0);
		run_cmd(CMD_START, 8'h00, 1'b0, SDA_RAND, 0);
		finish_phase();
		program_regs(12'd2, 12'd3, 12'd5, 1'b0);
		run_cmd(CMD_WAKE, 8'h00, 1'b0, SDA_RAND, 0);
		random_run(100, 1'b0);
		// random small setting; second half runs with no idling
		program_regs(CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(1, 40)),
			CFG_W'($urandom_range(1, 40)), 1'b0);
		random_run(250, 1'b1);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
